/* rtl/qapc_pkg.sv */
package qapc_pkg;

    // default sizes
    localparam int MAX_N_DEF       = 32;
    localparam int WEIGHT_BITS_DEF = 16;

    // fixed field widths
    localparam int IDX_FIELD_W = 5;
    localparam int SIZE_W      = 6;
    localparam int DELTA_W     = 40;
    localparam int COST_W      = 42;

    localparam logic [COST_W-1:0] COST_MAX  = {COST_W{1'b1}};
    localparam logic [COST_W-1:0] DELTA_MAX = {{(COST_W-39){1'b0}}, {39{1'b1}}};

    // operation codes
    localparam logic [2:0] MODE_WR_FLOW = 3'd0;
    localparam logic [2:0] MODE_WR_DIST = 3'd1;
    localparam logic [2:0] MODE_CLEAR   = 3'd2;
    localparam logic [2:0] MODE_ADD     = 3'd3;
    localparam logic [2:0] MODE_REMOVE  = 3'd4;
    localparam logic [2:0] MODE_EVAL    = 3'd5;

    // status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_TAKEN   = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_NOTDONE = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_INC   = 4'b0010,
        ST_EVAL  = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // kind of work in the product pipeline
    typedef enum logic [2:0] {
        K_SELF,
        K_CA,
        K_CB,
        K_LOC,
        K_PI,
        K_EV
    } kind_t;

endpackage

/* rtl/qapc_mat_mem.sv */
module qapc_mat_mem #(
    parameter int MAX_N       = qapc_pkg::MAX_N_DEF,
    parameter int WEIGHT_BITS = qapc_pkg::WEIGHT_BITS_DEF,
    localparam int AW         = $clog2(MAX_N * MAX_N)
) (
    input  logic                   clk,
    input  logic                   flow_we,
    input  logic                   dist_we,
    input  logic [AW-1:0]          waddr,
    input  logic [WEIGHT_BITS-1:0] wdata,
    input  logic                   rd_en,
    input  logic [AW-1:0]          flow_raddr,
    input  logic [AW-1:0]          dist_raddr,
    output logic [WEIGHT_BITS-1:0] flow_q,
    output logic [WEIGHT_BITS-1:0] dist_q
);

    logic [WEIGHT_BITS-1:0] flow_mem [MAX_N*MAX_N];
    logic [WEIGHT_BITS-1:0] dist_mem [MAX_N*MAX_N];

    // flow matrix
    always_ff @(posedge clk)
    begin
        if (flow_we)
        begin
            flow_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            flow_q <= flow_mem[flow_raddr];
        end
    end

    // distance matrix
    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[waddr] <= wdata;
        end
        if (rd_en)
        begin
            dist_q <= dist_mem[dist_raddr];
        end
    end

endmodule

/* rtl/qapc_place_mem.sv */
module qapc_place_mem #(
    parameter int MAX_N = qapc_pkg::MAX_N_DEF,
    localparam int IW   = $clog2(MAX_N)
) (
    input  logic          clk,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [IW-1:0] wdata,
    input  logic [IW-1:0] raddr,
    output logic [IW-1:0] rdata
);

    logic [IW-1:0] place_mem [MAX_N];

    // facility to location, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            place_mem[waddr] <= wdata;
        end
        rdata <= place_mem[raddr];
    end

endmodule

/* rtl/qap_partial_assignment_cost.sv */
// channel  | handshake          | fields
// ---------+--------------------+------------------------------------------
// command  | start, busy        | mode, row, col, weight, location
// config   | cfg_we             | cfg_data (size_n)
// result   | done (one cycle)   | status, delta, cost, assigned_count
//
// writes, clear, errors and unused modes: result in the cycle after the transfer.
// add and remove pass through the product pipeline: placement read, matrix read,
// multiply, accumulate.
// evaluate: one product per cycle plus one placement fetch per row.
// reset clears the assignment and sets size_n to MAX_N; matrices hold no reset.
// the receiver cannot stall: a result is shown for exactly the cycle done is high.
module qap_partial_assignment_cost #(
    parameter int MAX_N       = qapc_pkg::MAX_N_DEF,
    parameter int WEIGHT_BITS = qapc_pkg::WEIGHT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         mode,
    input  logic [4:0]         row,
    input  logic [4:0]         col,
    input  logic [15:0]        weight,
    input  logic [4:0]         location,
    input  logic               cfg_we,
    input  logic [5:0]         cfg_data,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [39:0] delta,
    output logic [41:0]        cost,
    output logic [5:0]         assigned_count
);

    localparam int IW    = $clog2(MAX_N);
    localparam int NW    = $clog2(MAX_N + 1);
    localparam int AW    = $clog2(MAX_N * MAX_N);
    localparam int PW    = 2 * WEIGHT_BITS;
    localparam int CW    = qapc_pkg::COST_W;
    localparam int DW    = qapc_pkg::DELTA_W;
    localparam int SUM_W = ((PW > CW) ? PW : CW) + 1;

    qapc_pkg::state_t state_reg;
    qapc_pkg::kind_t  s1_kind_reg;
    qapc_pkg::kind_t  iss_kind;

    logic [NW-1:0]     size_reg;
    logic [NW-1:0]     filled_reg;
    logic [MAX_N-1:0]  taken_reg;
    logic [CW-1:0]     run_reg;
    logic [2:0]        op_reg;
    logic [NW-1:0]     f_reg;
    logic [IW-1:0]     loc_reg;
    logic [IW-1:0]     pi_reg;
    logic [NW-1:0]     i_reg;
    logic [IW-1:0]     j_reg;
    logic              sub_reg;
    logic              pend_loc_reg;
    logic              pend_self_reg;
    logic              row_start_reg;
    logic [CW-1:0]     acc_reg;
    logic [CW-1:0]     lim_reg;
    logic              s1_valid_reg;
    logic [IW-1:0]     s1_fr_reg;
    logic [IW-1:0]     s1_fc_reg;
    logic              s2_valid_reg;
    logic              s3_valid_reg;
    logic [PW-1:0]     prod_reg;
    logic              done_reg;
    logic [1:0]        status_reg;
    logic [DW-1:0]     delta_reg;
    logic [CW-1:0]     cost_reg;
    logic [5:0]        count_reg;

    logic              accept;
    logic [6:0]        row_x;
    logic [6:0]        col_x;
    logic [6:0]        loc_x;
    logic [31:0]       weight_x;
    logic              wr_in_range;
    logic [AW-1:0]     wr_addr;
    logic [IW-1:0]     loc_idx;
    logic              loc_bad;
    logic [5:0]        size_clamped;
    logic [NW-1:0]     size_next;

    logic              iss_valid;
    logic [IW-1:0]     iss_fr;
    logic [IW-1:0]     iss_fc;
    logic [IW-1:0]     iss_pa;

    logic [IW-1:0]     place_rdata;
    logic              place_we;
    logic              mat_rd_en;
    logic [IW-1:0]     dr;
    logic [IW-1:0]     dc;
    logic [AW-1:0]     flow_raddr;
    logic [AW-1:0]     dist_raddr;
    logic [WEIGHT_BITS-1:0] flow_q;
    logic [WEIGHT_BITS-1:0] dist_q;

    logic [SUM_W-1:0]  acc_sum;
    logic [CW-1:0]     acc_next;
    logic              drain_done;
    logic [CW:0]       run_sum;
    logic [CW-1:0]     run_add_next;
    logic [CW-1:0]     run_sub_next;
    logic [6:0]        cnt_add_x;
    logic [6:0]        cnt_rm_x;
    logic [6:0]        cnt_now_x;

    assign busy   = (state_reg != qapc_pkg::ST_IDLE);
    assign accept = start && !busy;

    // input field decode
    assign row_x       = {2'b00, row};
    assign col_x       = {2'b00, col};
    assign loc_x       = {2'b00, location};
    assign weight_x    = {16'b0, weight};
    assign wr_in_range = (row_x < 7'(MAX_N)) && (col_x < 7'(MAX_N));
    assign wr_addr     = AW'(AW'(row_x[IW-1:0]) * AW'(MAX_N) + AW'(col_x[IW-1:0]));
    assign loc_idx     = loc_x[IW-1:0];
    assign loc_bad     = (loc_x >= 7'(size_reg)) || taken_reg[loc_idx];

    // size register clamp
    always_comb
    begin
        size_clamped = cfg_data;
        if (cfg_data < 6'd3)
        begin
            size_clamped = 6'd3;
        end
        if (7'(size_clamped) > 7'(MAX_N))
        begin
            size_next = NW'(MAX_N);
        end
        else
        begin
            size_next = NW'(size_clamped);
        end
    end

    // term issue sequencer
    always_comb
    begin
        iss_valid = 1'b0;
        iss_kind  = qapc_pkg::K_SELF;
        iss_fr    = f_reg[IW-1:0];
        iss_fc    = f_reg[IW-1:0];
        iss_pa    = i_reg[IW-1:0];
        if (state_reg == qapc_pkg::ST_INC)
        begin
            if (pend_loc_reg)
            begin
                iss_valid = 1'b1;
                iss_kind  = qapc_pkg::K_LOC;
                iss_pa    = f_reg[IW-1:0];
            end
            else if (pend_self_reg)
            begin
                iss_valid = 1'b1;
                iss_kind  = qapc_pkg::K_SELF;
            end
            else if (i_reg < f_reg)
            begin
                iss_valid = 1'b1;
                if (sub_reg)
                begin
                    iss_kind = qapc_pkg::K_CB;
                    iss_fr   = i_reg[IW-1:0];
                end
                else
                begin
                    iss_kind = qapc_pkg::K_CA;
                    iss_fc   = i_reg[IW-1:0];
                end
            end
        end
        else if (state_reg == qapc_pkg::ST_EVAL)
        begin
            if (i_reg != size_reg)
            begin
                iss_valid = 1'b1;
                iss_fr    = i_reg[IW-1:0];
                iss_fc    = j_reg;
                if (row_start_reg)
                begin
                    iss_kind = qapc_pkg::K_PI;
                end
                else
                begin
                    iss_kind = qapc_pkg::K_EV;
                    iss_pa   = j_reg;
                end
            end
        end
    end

    // stage 1: placement known, form matrix addresses
    always_comb
    begin
        mat_rd_en = 1'b0;
        dr        = loc_reg;
        dc        = loc_reg;
        if (s1_valid_reg)
        begin
            case (s1_kind_reg)
                qapc_pkg::K_SELF:
                begin
                    mat_rd_en = 1'b1;
                end
                qapc_pkg::K_CA:
                begin
                    mat_rd_en = 1'b1;
                    dc        = place_rdata;
                end
                qapc_pkg::K_CB:
                begin
                    mat_rd_en = 1'b1;
                    dr        = place_rdata;
                end
                qapc_pkg::K_EV:
                begin
                    mat_rd_en = 1'b1;
                    dr        = pi_reg;
                    dc        = place_rdata;
                end
                default:
                begin
                    mat_rd_en = 1'b0;
                end
            endcase
        end
    end

    assign flow_raddr = AW'(AW'(s1_fr_reg) * AW'(MAX_N) + AW'(s1_fc_reg));
    assign dist_raddr = AW'(AW'(dr) * AW'(MAX_N) + AW'(dc));

    // saturating accumulate
    assign acc_sum  = SUM_W'(acc_reg) + SUM_W'(prod_reg);
    assign acc_next = (acc_sum > SUM_W'(lim_reg)) ? lim_reg : acc_sum[CW-1:0];

    // finish values
    assign drain_done   = (state_reg == qapc_pkg::ST_DRAIN) && !s1_valid_reg
                          && !s2_valid_reg && !s3_valid_reg;
    assign run_sum      = {1'b0, run_reg} + {1'b0, acc_reg};
    assign run_add_next = (run_sum > {1'b0, qapc_pkg::COST_MAX}) ? qapc_pkg::COST_MAX
                                                                 : run_sum[CW-1:0];
    assign run_sub_next = (run_reg > acc_reg) ? (run_reg - acc_reg) : '0;
    assign cnt_add_x    = 7'(f_reg + NW'(1));
    assign cnt_rm_x     = 7'(f_reg);
    assign cnt_now_x    = 7'(filled_reg);
    assign place_we     = drain_done && (op_reg == qapc_pkg::MODE_ADD);

    qapc_mat_mem #(
        .MAX_N       (MAX_N),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_mat (
        .clk        (clk),
        .flow_we    (accept && (mode == qapc_pkg::MODE_WR_FLOW) && wr_in_range),
        .dist_we    (accept && (mode == qapc_pkg::MODE_WR_DIST) && wr_in_range),
        .waddr      (wr_addr),
        .wdata      (weight_x[WEIGHT_BITS-1:0]),
        .rd_en      (mat_rd_en),
        .flow_raddr (flow_raddr),
        .dist_raddr (dist_raddr),
        .flow_q     (flow_q),
        .dist_q     (dist_q)
    );

    qapc_place_mem #(
        .MAX_N (MAX_N)
    ) u_place (
        .clk   (clk),
        .we    (place_we),
        .waddr (f_reg[IW-1:0]),
        .wdata (loc_reg),
        .raddr (iss_pa),
        .rdata (place_rdata)
    );

    // control, pipeline and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= qapc_pkg::ST_IDLE;
            size_reg      <= NW'(MAX_N);
            filled_reg    <= '0;
            taken_reg     <= '0;
            run_reg       <= '0;
            op_reg        <= qapc_pkg::MODE_CLEAR;
            f_reg         <= '0;
            loc_reg       <= '0;
            pi_reg        <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            sub_reg       <= 1'b0;
            pend_loc_reg  <= 1'b0;
            pend_self_reg <= 1'b0;
            row_start_reg <= 1'b0;
            acc_reg       <= '0;
            lim_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s1_kind_reg   <= qapc_pkg::K_SELF;
            s1_fr_reg     <= '0;
            s1_fc_reg     <= '0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            prod_reg      <= '0;
            done_reg      <= 1'b0;
            status_reg    <= qapc_pkg::STAT_OK;
            delta_reg     <= '0;
            cost_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            done_reg <= 1'b0;

            // product pipeline
            s1_valid_reg <= iss_valid;
            s1_kind_reg  <= iss_kind;
            s1_fr_reg    <= iss_fr;
            s1_fc_reg    <= iss_fc;
            s2_valid_reg <= mat_rd_en;
            s3_valid_reg <= s2_valid_reg;
            prod_reg     <= PW'(flow_q) * PW'(dist_q);
            if (s3_valid_reg)
            begin
                acc_reg <= acc_next;
            end
            if (s1_valid_reg && (s1_kind_reg == qapc_pkg::K_LOC))
            begin
                loc_reg <= place_rdata;
            end
            if (s1_valid_reg && (s1_kind_reg == qapc_pkg::K_PI))
            begin
                pi_reg <= place_rdata;
            end

            // configuration write clears the assignment
            if (cfg_we)
            begin
                size_reg   <= size_next;
                filled_reg <= '0;
                taken_reg  <= '0;
                run_reg    <= '0;
            end

            unique case (state_reg)
                qapc_pkg::ST_IDLE:
                begin
                    if (accept)
                    begin
                        status_reg <= qapc_pkg::STAT_OK;
                        delta_reg  <= '0;
                        cost_reg   <= run_reg;
                        count_reg  <= cnt_now_x[5:0];
                        done_reg   <= 1'b1;
                        op_reg     <= mode;
                        acc_reg    <= '0;
                        i_reg      <= '0;
                        j_reg      <= '0;
                        sub_reg    <= 1'b0;
                        case (mode)
                            qapc_pkg::MODE_CLEAR:
                            begin
                                filled_reg <= '0;
                                taken_reg  <= '0;
                                run_reg    <= '0;
                                cost_reg   <= '0;
                                count_reg  <= '0;
                            end
                            qapc_pkg::MODE_ADD:
                            begin
                                if (filled_reg >= size_reg)
                                begin
                                    status_reg <= qapc_pkg::STAT_FULL;
                                end
                                else if (loc_bad)
                                begin
                                    status_reg <= qapc_pkg::STAT_TAKEN;
                                end
                                else
                                begin
                                    done_reg      <= 1'b0;
                                    f_reg         <= filled_reg;
                                    loc_reg       <= loc_idx;
                                    pend_loc_reg  <= 1'b0;
                                    pend_self_reg <= 1'b1;
                                    lim_reg       <= qapc_pkg::DELTA_MAX;
                                    state_reg     <= qapc_pkg::ST_INC;
                                end
                            end
                            qapc_pkg::MODE_REMOVE:
                            begin
                                if (filled_reg == '0)
                                begin
                                    status_reg <= qapc_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    done_reg      <= 1'b0;
                                    f_reg         <= filled_reg - NW'(1);
                                    pend_loc_reg  <= 1'b1;
                                    pend_self_reg <= 1'b1;
                                    lim_reg       <= qapc_pkg::DELTA_MAX;
                                    state_reg     <= qapc_pkg::ST_INC;
                                end
                            end
                            qapc_pkg::MODE_EVAL:
                            begin
                                if (filled_reg < size_reg)
                                begin
                                    status_reg <= qapc_pkg::STAT_NOTDONE;
                                end
                                else
                                begin
                                    done_reg      <= 1'b0;
                                    row_start_reg <= 1'b1;
                                    lim_reg       <= qapc_pkg::COST_MAX;
                                    state_reg     <= qapc_pkg::ST_EVAL;
                                end
                            end
                            default:
                            begin
                                status_reg <= qapc_pkg::STAT_OK;
                            end
                        endcase
                    end
                end
                qapc_pkg::ST_INC:
                begin
                    if (pend_loc_reg)
                    begin
                        pend_loc_reg <= 1'b0;
                    end
                    else if (pend_self_reg)
                    begin
                        pend_self_reg <= 1'b0;
                    end
                    else if (i_reg < f_reg)
                    begin
                        sub_reg <= !sub_reg;
                        if (sub_reg)
                        begin
                            i_reg <= i_reg + NW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= qapc_pkg::ST_DRAIN;
                    end
                end
                qapc_pkg::ST_EVAL:
                begin
                    if (i_reg == size_reg)
                    begin
                        state_reg <= qapc_pkg::ST_DRAIN;
                    end
                    else if (row_start_reg)
                    begin
                        row_start_reg <= 1'b0;
                        j_reg         <= '0;
                    end
                    else if (NW'(j_reg) == size_reg - NW'(1))
                    begin
                        i_reg         <= i_reg + NW'(1);
                        row_start_reg <= 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + IW'(1);
                    end
                end
                qapc_pkg::ST_DRAIN:
                begin
                    if (drain_done)
                    begin
                        state_reg  <= qapc_pkg::ST_IDLE;
                        done_reg   <= 1'b1;
                        status_reg <= qapc_pkg::STAT_OK;
                        if (op_reg == qapc_pkg::MODE_ADD)
                        begin
                            filled_reg         <= f_reg + NW'(1);
                            taken_reg[loc_reg] <= 1'b1;
                            run_reg            <= run_add_next;
                            delta_reg          <= acc_reg[DW-1:0];
                            cost_reg           <= run_add_next;
                            count_reg          <= cnt_add_x[5:0];
                        end
                        else if (op_reg == qapc_pkg::MODE_REMOVE)
                        begin
                            filled_reg         <= f_reg;
                            taken_reg[loc_reg] <= 1'b0;
                            run_reg            <= run_sub_next;
                            delta_reg          <= DW'(0) - acc_reg[DW-1:0];
                            cost_reg           <= run_sub_next;
                            count_reg          <= cnt_rm_x[5:0];
                        end
                        else
                        begin
                            delta_reg <= '0;
                            cost_reg  <= acc_reg;
                            count_reg <= cnt_now_x[5:0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= qapc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // result ports
    assign done           = done_reg;
    assign status         = status_reg;
    assign delta          = delta_reg;
    assign cost           = cost_reg;
    assign assigned_count = count_reg;

endmodule
